@@ hw/rtl/ssd_pkg.sv @@
`timescale 1ns / 1ps

package ssd_pkg;

    // Display geometry (fixed by the pin-out of the result fields)
    localparam int NUM_DIGITS   = 4;
    localparam int NUM_SEGMENTS = 7;
    localparam int DIGIT_IDX_W  = $clog2(NUM_DIGITS);
    localparam int SEG_IDX_W    = $clog2(NUM_SEGMENTS);
    localparam int VALUE_W      = 14;
    localparam int BCD_W        = 4;

    // Input kinds carried on s_tuser
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef logic [NUM_DIGITS-1:0][BCD_W-1:0] digits_t;

    // One request leaving the input register
    typedef struct packed {
        logic               load;
        logic               tick;
        logic [VALUE_W-1:0] value;
    } ssd_req_t;

    // Held pin drive
    typedef struct packed {
        logic [NUM_SEGMENTS-1:0] seg;
        logic [NUM_DIGITS-1:0]   cath_n;
    } ssd_drive_t;

    // Segment patterns, bit0 = A .. bit6 = G
    function automatic logic [NUM_SEGMENTS-1:0] glyph(input logic [BCD_W-1:0] dig);
        logic [NUM_SEGMENTS-1:0] pat;
        case (dig)
            4'd0:    pat = 7'b0111111;
            4'd1:    pat = 7'b0000110;
            4'd2:    pat = 7'b1011011;
            4'd3:    pat = 7'b1001111;
            4'd4:    pat = 7'b1100110;
            4'd5:    pat = 7'b1101101;
            4'd6:    pat = 7'b1111101;
            4'd7:    pat = 7'b0000111;
            4'd8:    pat = 7'b1111111;
            4'd9:    pat = 7'b1101111;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

@@ hw/rtl/ssd_bcd.sv @@
`timescale 1ns / 1ps

// Binary to four decimal digits, value modulo 10000.
// Quotients by 10, 100 and 1000 come from independent reciprocal multiplies.
module ssd_bcd (
    input  logic [ssd_pkg::VALUE_W-1:0] value,
    output ssd_pkg::digits_t            digits
);
    import ssd_pkg::*;

    localparam int          PW     = 28;
    localparam logic [13:0] MOD_C  = 14'd10000;
    localparam logic [PW-1:0] RCP10   = 28'd6554;  // 2^16 / 10, rounded up
    localparam logic [PW-1:0] RCP100  = 28'd5243;  // 2^19 / 100, rounded up
    localparam logic [PW-1:0] RCP1000 = 28'd8389;  // 2^23 / 1000, rounded up

    function automatic logic [VALUE_W-1:0] times10(input logic [VALUE_W-1:0] x);
        return (x << 3) + (x << 1);
    endfunction

    logic [VALUE_W-1:0] vm;
    logic [PW-1:0]      prod10, prod100, prod1000;
    logic [VALUE_W-1:0] q1, q2, q3;
    logic [VALUE_W-1:0] r0, r1, r2;

    // Input is below twice the modulus: one compare and subtract
    assign vm = (value >= MOD_C) ? value - MOD_C : value;

    assign prod10   = {{(PW-VALUE_W){1'b0}}, vm} * RCP10;
    assign prod100  = {{(PW-VALUE_W){1'b0}}, vm} * RCP100;
    assign prod1000 = {{(PW-VALUE_W){1'b0}}, vm} * RCP1000;

    assign q1 = {4'b0, prod10[25:16]};
    assign q2 = {7'b0, prod100[25:19]};
    assign q3 = {10'b0, prod1000[26:23]};

    // Remainders at each decade
    assign r0 = vm - times10(q1);
    assign r1 = q1 - times10(q2);
    assign r2 = q2 - times10(q3);

    assign digits[0] = r0[BCD_W-1:0];
    assign digits[1] = r1[BCD_W-1:0];
    assign digits[2] = r2[BCD_W-1:0];
    assign digits[3] = q3[BCD_W-1:0];

endmodule

@@ hw/rtl/ssd_scan.sv @@
`timescale 1ns / 1ps

// Digit store, scan counters and held pin drive.
module ssd_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  ssd_pkg::ssd_req_t   req,
    input  ssd_pkg::digits_t    load_digits,
    input  logic                display_enable,
    output ssd_pkg::ssd_drive_t drive_next
);
    import ssd_pkg::*;

    digits_t                digits_reg, digits_next;
    logic [DIGIT_IDX_W-1:0] digit_idx_reg, digit_idx_next;
    logic [SEG_IDX_W-1:0]   seg_idx_reg, seg_idx_next;
    ssd_drive_t             drive_reg;

    logic                    tick;
    logic [NUM_DIGITS-1:0]   nonzero_above;
    logic [NUM_DIGITS-1:0]   blanked;
    logic [BCD_W-1:0]        cur_digit;
    logic [NUM_SEGMENTS-1:0] seg_onehot;

    assign tick = req.tick & display_enable;

    // Leading-zero blanking: digit k>0 blanked when it and all higher digits are zero
    always_comb begin
        nonzero_above[NUM_DIGITS-1] = (digits_reg[NUM_DIGITS-1] != '0);
        for (int k = NUM_DIGITS - 2; k >= 0; k--) begin
            nonzero_above[k] = nonzero_above[k+1] | (digits_reg[k] != '0);
        end
        blanked = ~nonzero_above;
        blanked[0] = 1'b0;
    end

    assign cur_digit  = digits_reg[digit_idx_reg];
    assign seg_onehot = NUM_SEGMENTS'(1) << seg_idx_reg;

    // Next drive and counters
    always_comb begin
        digits_next    = digits_reg;
        digit_idx_next = digit_idx_reg;
        seg_idx_next   = seg_idx_reg;
        drive_next     = drive_reg;
        if (req.load) begin
            digits_next = load_digits;
        end
        if (tick) begin
            drive_next.cath_n = '1;
            if (!blanked[digit_idx_reg]) begin
                drive_next.cath_n[digit_idx_reg] = 1'b0;
            end
            drive_next.seg = glyph(cur_digit) & seg_onehot;
            if (seg_idx_reg == SEG_IDX_W'(NUM_SEGMENTS - 1)) begin
                seg_idx_next = '0;
                if (digit_idx_reg == DIGIT_IDX_W'(NUM_DIGITS - 1)) begin
                    digit_idx_next = '0;
                end else begin
                    digit_idx_next = digit_idx_reg + 1'b1;
                end
            end else begin
                seg_idx_next = seg_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg    <= '0;
            digit_idx_reg <= '0;
            seg_idx_reg   <= '0;
            drive_reg     <= '{seg: '0, cath_n: '1};
        end else begin
            digits_reg    <= digits_next;
            digit_idx_reg <= digit_idx_next;
            seg_idx_reg   <= seg_idx_next;
            drive_reg     <= drive_next;
        end
    end

endmodule

@@ hw/rtl/seven_segment_scan_driver.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser = cmd, s_tdata = value
// m_        out  m_tvalid/m_tready  m_tdata = digit_enable_n, segment_drive
// cfg_      in   cfg_we             cfg_wdata = display_enable
//
// One request per cycle sustained while m_tready is high; each request's result
// reaches m_tdata through the input register, then the result register.
// The scan update and the decimal conversion sit between those two registers.
// aresetn is synchronous: digits zero, counters zero, held drive all digits off.
// A stalled result holds; the input register still takes one more request.
module seven_segment_scan_driver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] cmd
    input  logic [15:0] s_tdata,   // [13:0] value, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] digit_enable_n, [10:4] segment_drive
    input  logic        cfg_we,
    input  logic        cfg_wdata  // display_enable
);
    import ssd_pkg::*;

    logic               in_valid_reg, in_valid_next;
    logic               in_cmd_reg;
    logic [VALUE_W-1:0] in_value_reg;
    logic               m_valid_reg, m_valid_next;
    ssd_drive_t         m_drive_reg;
    logic               display_enable_reg;

    logic       out_free;
    logic       in_fire;
    ssd_req_t   req;
    digits_t    load_digits;
    ssd_drive_t drive_next;

    assign out_free = !m_valid_reg || m_tready;
    assign in_fire  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign req.load  = in_fire && (in_cmd_reg == CMD_LOAD);
    assign req.tick  = in_fire && (in_cmd_reg == CMD_TICK);
    assign req.value = in_value_reg;

    ssd_bcd u_bcd (
        .value  (in_value_reg),
        .digits (load_digits)
    );

    ssd_scan u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (req),
        .load_digits    (load_digits),
        .display_enable (display_enable_reg),
        .drive_next     (drive_next)
    );

    // Handshake control
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (in_fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            display_enable_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                display_enable_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= s_tuser;
            in_value_reg <= s_tdata[VALUE_W-1:0];
        end
        if (in_fire) begin
            m_drive_reg <= drive_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_drive_reg.seg, m_drive_reg.cath_n};

endmodule

@@ hw/rtl/ssd_checker.sv @@
`timescale 1ns / 1ps

module ssd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // At most one digit selected
    a_one_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(~m_tdata[3:0]) <= 1)
        else $error("more than one cathode driven");

    // At most one segment lit, padding clear
    a_one_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(m_tdata[10:4]) <= 1 && m_tdata[15:11] == 5'b0)
        else $error("bad segment drive");

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (.*);
